// ===== src/jaef_pkg.sv =====
// Shared types and constants for the joystick and accelerometer event filter.
`default_nettype none

package jaef_pkg;

    // Default depth of the moving-average windows
    localparam int WINDOW_DEFAULT = 8;

    // Field widths
    localparam int JOY_W      = 8;
    localparam int ACCEL_W    = 10;
    localparam int FLAGS_W    = 8;
    localparam int OFFSET_W   = 11;

    // Input tdata layout, lowest bit first
    localparam int IN_JOY_X_LSB   = 0;
    localparam int IN_JOY_Y_LSB   = 8;
    localparam int IN_ACCEL_LSB   = 16;
    localparam int IN_FLAGS_LSB   = 24;
    localparam int IN_QUIET_BIT   = 32;
    localparam int IN_TDATA_W     = 40;

    // Bits inside the flags byte
    localparam int FLAG_Z_BIT     = 0;
    localparam int FLAG_C_BIT     = 1;
    localparam int FLAG_ACCEL_LSB = 2;

    // Output channel widths
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 3;
    localparam int OUT_KIND_LSB = 0;
    localparam int OUT_CHAN_BIT = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    // Snap ranges around the center
    localparam int JOY_SNAP   = 1;
    localparam int ACCEL_SNAP = 10;

    // Events one report can raise
    localparam int EVENT_SLOTS = 5;

    typedef enum logic [1:0] {
        EV_JOY   = 2'd0,
        EV_ACCEL = 2'd1,
        EV_DOWN  = 2'd2,
        EV_UP    = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_JOY_X_CENTER   = 2'd0,
        CFG_JOY_Y_CENTER   = 2'd1,
        CFG_ACCEL_X_CENTER = 2'd2
    } cfg_index_t;

    // Channel codes: axis X or button Z, axis Y or button C
    localparam logic CH_X = 1'b0;
    localparam logic CH_Y = 1'b1;
    localparam logic CH_Z = 1'b0;
    localparam logic CH_C = 1'b1;

    typedef struct packed {
        event_kind_t                kind;
        logic                       chan;
        logic signed [OFFSET_W-1:0] offset;
    } event_t;

endpackage

`default_nettype wire

// ===== src/joystick_accel_event_filter.sv =====
// Moving-average, deadband and button-edge event filter for controller reports.
`default_nettype none

// Each accepted report pushes joystick X, joystick Y and the ten-bit accelerometer X
// into WINDOW-deep moving averages, compares the rounded means against the last
// reported values and raises up to five events (joystick X, joystick Y, accel X,
// button Z, button C, in that order), the final one marked by m_axis_tlast. A report
// passes an input register, a running-sum stage, a mean stage (one constant
// multiplication per channel) and a tracking stage, which loads its events into a
// five-entry result buffer. Events leave that buffer one per cycle while m_axis_tready
// is high; a report's events hold it until the last one is taken, and the next report's
// events load as that last one leaves, so that single output port sets the report rate.
// The window samples sit in one memory of WINDOW entries read ahead one slot; entries
// count as zero until the first pass over the window is complete. Configuration
// writes are always taken (cfg_ready stays high) and must only occur while idle.
module joystick_accel_event_filter #(
    parameter int WINDOW = jaef_pkg::WINDOW_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Report input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // joy_x[7:0], joy_y[15:8], accel_x_high[23:16], flags_byte[31:24], quiet[32]
    input  wire logic [jaef_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Event output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // offset[10:0], zero fill above
    output logic [jaef_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // event_kind[1:0], channel[2]
    output logic [jaef_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
    output logic                                    m_axis_tlast,
    // Configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [jaef_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [jaef_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int JOY_W    = jaef_pkg::JOY_W;
    localparam int ACCEL_W  = jaef_pkg::ACCEL_W;
    localparam int OFFSET_W = jaef_pkg::OFFSET_W;
    localparam int SLOTS    = jaef_pkg::EVENT_SLOTS;

    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int SAMPLE_W = 2 * JOY_W + ACCEL_W;
    localparam int JSUM_W   = $clog2(WINDOW * 255 + 1);
    localparam int ASUM_W   = $clog2(WINDOW * 1023 + 1);

    // Rounded mean floor((2*sum + WINDOW) / (2*WINDOW)) by reciprocal multiplication
    localparam int DIV_D    = 2 * WINDOW;
    localparam int DIV_N    = ASUM_W + 2;
    localparam int DIV_S    = DIV_N + $clog2(DIV_D);
    localparam int DIV_M_W  = DIV_N + 2;
    localparam int PROD_W   = DIV_N + DIV_M_W;
    localparam longint DIV_M_VAL =
        ((longint'(1) << DIV_S) + longint'(DIV_D - 1)) / longint'(DIV_D);
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_VAL);

    localparam int TRK_W = ACCEL_W + 2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    typedef struct packed {
        logic               change;
        logic [ACCEL_W-1:0] value;
    } track_t;

    // Deadband compare and snap to center
    function automatic track_t track_value(
        input logic [ACCEL_W-1:0]      rep,
        input logic [ACCEL_W-1:0]      mean,
        input logic [ACCEL_W-1:0]      center,
        input logic signed [TRK_W-1:0] snap
    );
        logic signed [TRK_W-1:0] diff;
        logic signed [TRK_W-1:0] m;
        logic signed [TRK_W-1:0] lo;
        logic signed [TRK_W-1:0] hi;
        track_t                  r;
        m      = $signed({2'b00, mean});
        diff   = $signed({2'b00, rep}) - m;
        lo     = $signed({2'b00, center}) - snap;
        hi     = $signed({2'b00, center}) + snap;
        r.change = (diff > TRK_W'(1)) || (diff < -TRK_W'(1));
        if (!r.change)
            r.value = rep;
        else if (m >= lo && m <= hi)
            r.value = center;
        else
            r.value = mean;
        return r;
    endfunction

    // Configuration registers
    logic [JOY_W-1:0]   jx_center_reg;
    logic [JOY_W-1:0]   jy_center_reg;
    logic [ACCEL_W-1:0] ax_center_reg;

    // Input stage
    logic               a_valid_reg;
    logic [JOY_W-1:0]   a_jx_reg;
    logic [JOY_W-1:0]   a_jy_reg;
    logic [ACCEL_W-1:0] a_ax_reg;
    logic               a_z_rel_reg;
    logic               a_c_rel_reg;
    logic               a_quiet_reg;

    // Window memory and running sums
    logic [SAMPLE_W-1:0] window_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SLOT_W-1:0]   rd_addr;
    logic                filled_reg;
    logic [SAMPLE_W-1:0] old_sample;
    logic [JSUM_W-1:0]   jx_sum_reg;
    logic [JSUM_W-1:0]   jy_sum_reg;
    logic [ASUM_W-1:0]   ax_sum_reg;
    logic [JSUM_W-1:0]   jx_sum_next;
    logic [JSUM_W-1:0]   jy_sum_next;
    logic [ASUM_W-1:0]   ax_sum_next;

    // Sum stage
    logic b_valid_reg;
    logic b_z_rel_reg;
    logic b_c_rel_reg;
    logic b_quiet_reg;

    // Mean computation
    logic [DIV_N-1:0]  jx_num;
    logic [DIV_N-1:0]  jy_num;
    logic [DIV_N-1:0]  ax_num;
    logic [PROD_W-1:0] jx_prod;
    logic [PROD_W-1:0] jy_prod;
    logic [PROD_W-1:0] ax_prod;

    // Mean stage
    logic               c_valid_reg;
    logic [JOY_W-1:0]   c_jx_mean_reg;
    logic [JOY_W-1:0]   c_jy_mean_reg;
    logic [ACCEL_W-1:0] c_ax_mean_reg;
    logic               c_z_rel_reg;
    logic               c_c_rel_reg;
    logic               c_quiet_reg;

    // Tracking state
    logic [JOY_W-1:0]   jx_rep_reg;
    logic [JOY_W-1:0]   jy_rep_reg;
    logic [ACCEL_W-1:0] ax_rep_reg;
    logic               z_pressed_reg;
    logic               c_pressed_reg;
    track_t             jx_trk;
    track_t             jy_trk;
    track_t             ax_trk;
    logic               z_press_now;
    logic               c_press_now;
    logic [SLOTS-1:0]   ev_valid;
    jaef_pkg::event_t   ev_new [SLOTS];

    // Result buffer
    jaef_pkg::event_t   ev_reg [SLOTS];
    logic [SLOTS-1:0]   pend_reg;
    logic [SLOTS-1:0]   sel_onehot;
    logic [SLOTS-1:0]   pend_after;
    jaef_pkg::event_t   out_ev;

    // Handshake
    logic out_fire;
    logic buf_free;
    logic c_ready;
    logic c_move;
    logic b_ready;
    logic b_move;
    logic a_ready;
    logic a_move;
    logic in_fire;

    // Pipeline flow control
    always_comb
    begin
        out_fire   = m_axis_tvalid && m_axis_tready;
        pend_after = pend_reg & ~(out_fire ? sel_onehot : '0);
        buf_free   = (pend_after == '0);
        c_move     = c_valid_reg && buf_free;
        c_ready    = !c_valid_reg || buf_free;
        b_move     = b_valid_reg && c_ready;
        b_ready    = !b_valid_reg || c_ready;
        a_move     = a_valid_reg && b_ready;
        a_ready    = !a_valid_reg || b_ready;
        in_fire    = s_axis_tvalid && a_ready;
    end

    assign s_axis_tready = a_ready;
    assign cfg_ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jx_center_reg <= JOY_W'(128);
            jy_center_reg <= JOY_W'(128);
            ax_center_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (jaef_pkg::cfg_index_t'(cfg_index))
                jaef_pkg::CFG_JOY_X_CENTER:   jx_center_reg <= cfg_data[JOY_W-1:0];
                jaef_pkg::CFG_JOY_Y_CENTER:   jy_center_reg <= cfg_data[JOY_W-1:0];
                jaef_pkg::CFG_ACCEL_X_CENTER: ax_center_reg <= cfg_data[ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the report
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_jx_reg    <= s_axis_tdata[jaef_pkg::IN_JOY_X_LSB +: JOY_W];
            a_jy_reg    <= s_axis_tdata[jaef_pkg::IN_JOY_Y_LSB +: JOY_W];
            a_ax_reg    <= {s_axis_tdata[jaef_pkg::IN_ACCEL_LSB +: JOY_W],
                            s_axis_tdata[jaef_pkg::IN_FLAGS_LSB + jaef_pkg::FLAG_ACCEL_LSB +: 2]};
            a_z_rel_reg <= s_axis_tdata[jaef_pkg::IN_FLAGS_LSB + jaef_pkg::FLAG_Z_BIT];
            a_c_rel_reg <= s_axis_tdata[jaef_pkg::IN_FLAGS_LSB + jaef_pkg::FLAG_C_BIT];
            a_quiet_reg <= s_axis_tdata[jaef_pkg::IN_QUIET_BIT];
        end
    end

    // Replace the oldest sample and update the running sums
    always_comb
    begin
        slot_next   = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
        rd_addr     = a_move ? slot_next : slot_reg;
        old_sample  = filled_reg ? rd_reg : '0;
        jx_sum_next = jx_sum_reg - JSUM_W'(old_sample[0 +: JOY_W]) + JSUM_W'(a_jx_reg);
        jy_sum_next = jy_sum_reg - JSUM_W'(old_sample[JOY_W +: JOY_W]) + JSUM_W'(a_jy_reg);
        ax_sum_next = ax_sum_reg - ASUM_W'(old_sample[2 * JOY_W +: ACCEL_W])
                      + ASUM_W'(a_ax_reg);
    end

    // Window memory, read one slot ahead
    always_ff @(posedge clk)
    begin
        if (a_move)
            window_mem[slot_reg] <= {a_ax_reg, a_jy_reg, a_jx_reg};
        rd_reg <= window_mem[rd_addr];
    end

    // Mean numerators and reciprocal products
    always_comb
    begin
        jx_num  = DIV_N'({jx_sum_reg, 1'b0}) + DIV_N'(WINDOW);
        jy_num  = DIV_N'({jy_sum_reg, 1'b0}) + DIV_N'(WINDOW);
        ax_num  = DIV_N'({ax_sum_reg, 1'b0}) + DIV_N'(WINDOW);
        jx_prod = PROD_W'(jx_num) * PROD_W'(DIV_M);
        jy_prod = PROD_W'(jy_num) * PROD_W'(DIV_M);
        ax_prod = PROD_W'(ax_num) * PROD_W'(DIV_M);
    end

    // Deadband tracking and event build
    always_comb
    begin
        jx_trk = track_value({2'b00, jx_rep_reg}, {2'b00, c_jx_mean_reg},
                             {2'b00, jx_center_reg}, TRK_W'(jaef_pkg::JOY_SNAP));
        jy_trk = track_value({2'b00, jy_rep_reg}, {2'b00, c_jy_mean_reg},
                             {2'b00, jy_center_reg}, TRK_W'(jaef_pkg::JOY_SNAP));
        ax_trk = track_value(ax_rep_reg, c_ax_mean_reg, ax_center_reg,
                             TRK_W'(jaef_pkg::ACCEL_SNAP));
        z_press_now = !c_z_rel_reg;
        c_press_now = !c_c_rel_reg;

        ev_new[0].kind   = jaef_pkg::EV_JOY;
        ev_new[0].chan   = jaef_pkg::CH_X;
        ev_new[0].offset = $signed({3'b000, jx_trk.value[JOY_W-1:0]})
                           - $signed({3'b000, jx_center_reg});
        ev_new[1].kind   = jaef_pkg::EV_JOY;
        ev_new[1].chan   = jaef_pkg::CH_Y;
        ev_new[1].offset = $signed({3'b000, jy_center_reg})
                           - $signed({3'b000, jy_trk.value[JOY_W-1:0]});
        ev_new[2].kind   = jaef_pkg::EV_ACCEL;
        ev_new[2].chan   = jaef_pkg::CH_X;
        ev_new[2].offset = $signed({1'b0, ax_trk.value}) - $signed({1'b0, ax_center_reg});
        ev_new[3].kind   = z_press_now ? jaef_pkg::EV_DOWN : jaef_pkg::EV_UP;
        ev_new[3].chan   = jaef_pkg::CH_Z;
        ev_new[3].offset = '0;
        ev_new[4].kind   = c_press_now ? jaef_pkg::EV_DOWN : jaef_pkg::EV_UP;
        ev_new[4].chan   = jaef_pkg::CH_C;
        ev_new[4].offset = '0;

        ev_valid[0] = jx_trk.change && !c_quiet_reg;
        ev_valid[1] = jy_trk.change && !c_quiet_reg;
        ev_valid[2] = ax_trk.change;
        ev_valid[3] = (z_press_now != z_pressed_reg) && !c_quiet_reg;
        ev_valid[4] = (c_press_now != c_pressed_reg) && !c_quiet_reg;
    end

    // Advance stage payloads
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_z_rel_reg <= a_z_rel_reg;
            b_c_rel_reg <= a_c_rel_reg;
            b_quiet_reg <= a_quiet_reg;
        end
        if (b_move)
        begin
            c_jx_mean_reg <= jx_prod[DIV_S +: JOY_W];
            c_jy_mean_reg <= jy_prod[DIV_S +: JOY_W];
            c_ax_mean_reg <= ax_prod[DIV_S +: ACCEL_W];
            c_z_rel_reg   <= b_z_rel_reg;
            c_c_rel_reg   <= b_c_rel_reg;
            c_quiet_reg   <= b_quiet_reg;
        end
        if (c_move)
            ev_reg <= ev_new;
    end

    // Control state and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            slot_reg      <= '0;
            filled_reg    <= 1'b0;
            jx_sum_reg    <= '0;
            jy_sum_reg    <= '0;
            ax_sum_reg    <= '0;
            jx_rep_reg    <= '0;
            jy_rep_reg    <= '0;
            ax_rep_reg    <= '0;
            z_pressed_reg <= 1'b0;
            c_pressed_reg <= 1'b0;
            pend_reg      <= '0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= s_axis_tvalid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (a_move)
            begin
                slot_reg   <= slot_next;
                jx_sum_reg <= jx_sum_next;
                jy_sum_reg <= jy_sum_next;
                ax_sum_reg <= ax_sum_next;
                if (slot_reg == SLOT_LAST)
                    filled_reg <= 1'b1;
            end
            if (c_move)
            begin
                jx_rep_reg    <= jx_trk.value[JOY_W-1:0];
                jy_rep_reg    <= jy_trk.value[JOY_W-1:0];
                ax_rep_reg    <= ax_trk.value;
                z_pressed_reg <= z_press_now;
                c_pressed_reg <= c_press_now;
                pend_reg      <= ev_valid;
            end
            else
                pend_reg <= pend_after;
        end
    end

    // Drain the lowest pending event first
    always_comb
    begin
        sel_onehot = pend_reg & (~pend_reg + 1'b1);
        out_ev     = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel_onehot[i])
                out_ev = ev_reg[i];
        end
    end

    assign m_axis_tvalid = |pend_reg;
    assign m_axis_tdata  = {{(jaef_pkg::OUT_TDATA_W - OFFSET_W){1'b0}}, out_ev.offset};
    assign m_axis_tuser  = {out_ev.chan, out_ev.kind};
    assign m_axis_tlast  = ((pend_reg & ~sel_onehot) == '0);

endmodule

`default_nettype wire

// ===== src/jaef_checker.sv =====
// Port-level checks on the event filter's output channel, bound to the top level.
`default_nettype none

module jaef_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [jaef_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire logic [jaef_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    input wire logic                               m_axis_tlast
);

    // Hold a stalled event
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("event dropped while stalled");

    // Keep the rest of a report's events coming after a non-final transfer
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("report events ended without tlast");

    // Button events carry a zero offset
    a_button_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == jaef_pkg::EV_DOWN
                          || m_axis_tuser[1:0] == jaef_pkg::EV_UP)
        |-> m_axis_tdata[jaef_pkg::OFFSET_W-1:0] == '0)
        else $error("button event with nonzero offset");

    // Accelerometer events are on channel X only
    a_accel_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == jaef_pkg::EV_ACCEL
        |-> m_axis_tuser[jaef_pkg::OUT_CHAN_BIT] == jaef_pkg::CH_X)
        else $error("accelerometer event on wrong channel");

endmodule

bind joystick_accel_event_filter jaef_checker u_jaef_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/tb_joystick_accel_event_filter.sv =====
// Self-checking testbench for the joystick and accelerometer event filter.
`timescale 1ns / 1ps

module tb_joystick_accel_event_filter;

    localparam int WIN           = jaef_pkg::WINDOW_DEFAULT;
    localparam int BLOCK_LATENCY = 12;
    localparam int HOLD_CYCLES   = 250;
    localparam int PHASE_ITEMS   = 20;
    localparam int FILL_ITEMS    = 40;
    localparam int DIR_ROWS      = 22;

    localparam int IN_W     = jaef_pkg::IN_TDATA_W;
    localparam int CFG_W    = jaef_pkg::CFG_DATA_W;
    localparam int OFF_W    = jaef_pkg::OFFSET_W;
    localparam int KIND_LSB = jaef_pkg::OUT_KIND_LSB;
    localparam int CHAN_BIT = jaef_pkg::OUT_CHAN_BIT;

    // One controller report, joy_x in the lowest bits as on s_axis_tdata
    typedef struct packed {
        logic       quiet;
        logic [7:0] flags;
        logic [7:0] accel_high;
        logic [7:0] joy_y;
        logic [7:0] joy_x;
    } report_t;

    typedef struct packed {
        jaef_pkg::event_t ev;
        logic             last;
    } filter_event_t;

    // Directed row: report, typed-in expectation flag, one typed event if any
    typedef struct packed {
        report_t          rpt;
        logic             typed;
        logic             has_event;
        jaef_pkg::event_t ev;
    } stim_row_t;

    // Typed-in events of the directed rows
    localparam jaef_pkg::event_t NO_EV  = '{jaef_pkg::EV_JOY, jaef_pkg::CH_X, 11'sd0};
    localparam jaef_pkg::event_t Z_DOWN = '{jaef_pkg::EV_DOWN, jaef_pkg::CH_Z, 11'sd0};
    localparam jaef_pkg::event_t C_DOWN = '{jaef_pkg::EV_DOWN, jaef_pkg::CH_C, 11'sd0};

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [IN_W-1:0]                      s_axis_tdata = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [jaef_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic [jaef_pkg::OUT_TUSER_W-1:0]     m_axis_tuser;
    logic                                 m_axis_tlast;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [jaef_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]                     cfg_data = '0;

    joystick_accel_event_filter #(
        .WINDOW(WIN)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor copy of the centers
    int jx_center = 128;
    int jy_center = 128;
    int ax_center = 0;

    // Predictor copy of the filter state
    logic [jaef_pkg::JOY_W-1:0]   jx_window [WIN];
    logic [jaef_pkg::JOY_W-1:0]   jy_window [WIN];
    logic [jaef_pkg::ACCEL_W-1:0] ax_window [WIN];
    logic [10:0]                  jx_sum = '0;
    logic [10:0]                  jy_sum = '0;
    logic [12:0]                  ax_sum = '0;
    int                           jx_reported = 0;
    int                           jy_reported = 0;
    int                           ax_reported = 0;
    int                           slot_index = 0;
    logic                         z_pressed = 1'b0;
    logic                         c_pressed = 1'b0;

    filter_event_t report_events [$];
    filter_event_t pending_events [$];
    int            errors = 0;
    int            burst_left = 0;
    bit            no_gaps = 1'b0;
    int            hold_requests = 0;
    logic [1:0]    btn_bits = 2'b11;

    initial
    begin
        for (int i = 0; i < WIN; i++)
        begin
            jx_window[i] = '0;
            jy_window[i] = '0;
            ax_window[i] = '0;
        end
    end

    function automatic int rounded_mean(input int sum);
        return (2 * sum + WIN) / (2 * WIN);
    endfunction

    // Decide whether the mean moved far enough; snap it to the center if close
    function automatic bit track_channel(input int rep, input int mean, input int center,
                                         input int snap, output int rep_next);
        int d;
        d = rep - mean;
        if (d < 0)
            d = -d;
        rep_next = rep;
        if (d <= 1)
            return 1'b0;
        if (mean >= center - snap && mean <= center + snap)
            rep_next = center;
        else
            rep_next = mean;
        return 1'b1;
    endfunction

    function automatic void add_event(input jaef_pkg::event_kind_t kind, input logic chan,
                                      input int off);
        filter_event_t e;
        e.ev.kind   = kind;
        e.ev.chan   = chan;
        e.ev.offset = OFF_W'(off);
        e.last      = 1'b0;
        report_events.push_back(e);
    endfunction

    // Advance the predicted filter state by one report and collect its events
    task automatic filter_report(input report_t r);
        int                           mean;
        int                           rep;
        logic [jaef_pkg::ACCEL_W-1:0] ax;
        logic                         pz;
        logic                         pc;
        report_events.delete();
        ax = {r.accel_high, r.flags[jaef_pkg::FLAG_ACCEL_LSB+1:jaef_pkg::FLAG_ACCEL_LSB]};

        jx_sum = jx_sum - 11'(jx_window[slot_index]) + 11'(r.joy_x);
        jx_window[slot_index] = r.joy_x;
        mean = rounded_mean(int'(jx_sum));
        if (track_channel(jx_reported, mean, jx_center, jaef_pkg::JOY_SNAP, rep))
        begin
            jx_reported = rep;
            if (!r.quiet)
                add_event(jaef_pkg::EV_JOY, jaef_pkg::CH_X, jx_reported - jx_center);
        end

        jy_sum = jy_sum - 11'(jy_window[slot_index]) + 11'(r.joy_y);
        jy_window[slot_index] = r.joy_y;
        mean = rounded_mean(int'(jy_sum));
        if (track_channel(jy_reported, mean, jy_center, jaef_pkg::JOY_SNAP, rep))
        begin
            jy_reported = rep;
            if (!r.quiet)
                add_event(jaef_pkg::EV_JOY, jaef_pkg::CH_Y, jy_center - jy_reported);
        end

        // Accelerometer events ignore quiet
        ax_sum = ax_sum - 13'(ax_window[slot_index]) + 13'(ax);
        ax_window[slot_index] = ax;
        mean = rounded_mean(int'(ax_sum));
        if (track_channel(ax_reported, mean, ax_center, jaef_pkg::ACCEL_SNAP, rep))
        begin
            ax_reported = rep;
            add_event(jaef_pkg::EV_ACCEL, jaef_pkg::CH_X, ax_reported - ax_center);
        end

        slot_index = (slot_index + 1 >= WIN) ? 0 : slot_index + 1;

        // Buttons are active low
        pz = ~r.flags[jaef_pkg::FLAG_Z_BIT];
        if (pz != z_pressed)
        begin
            z_pressed = pz;
            if (!r.quiet)
                add_event(pz ? jaef_pkg::EV_DOWN : jaef_pkg::EV_UP, jaef_pkg::CH_Z, 0);
        end
        pc = ~r.flags[jaef_pkg::FLAG_C_BIT];
        if (pc != c_pressed)
        begin
            c_pressed = pc;
            if (!r.quiet)
                add_event(pc ? jaef_pkg::EV_DOWN : jaef_pkg::EV_UP, jaef_pkg::CH_C, 0);
        end

        if (report_events.size() > 0)
            report_events[report_events.size() - 1].last = 1'b1;
    endtask

    // Offer one report in the current burst; hold it until the transfer
    task automatic send_report(input report_t r, input bit typed, input bit typed_has,
                               input jaef_pkg::event_t typed_ev);
        int            gap;
        filter_event_t e;
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(r);
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;

        filter_report(r);
        if (typed)
        begin
            if (typed_has)
            begin
                e.ev   = typed_ev;
                e.last = 1'b1;
                pending_events.push_back(e);
            end
        end
        else
        begin
            foreach (report_events[i])
                pending_events.push_back(report_events[i]);
        end
    endtask

    // Stop sending and let the block drain completely
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (BLOCK_LATENCY) @(posedge clk);
    endtask

    // Write one center and then leave the channel idle
    task automatic write_center(input jaef_pkg::cfg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            jaef_pkg::CFG_JOY_X_CENTER:   jx_center = value & 8'hFF;
            jaef_pkg::CFG_JOY_Y_CENTER:   jy_center = value & 8'hFF;
            jaef_pkg::CFG_ACCEL_X_CENTER: ax_center = value & 10'h3FF;
            default: ;
        endcase
    endtask

    function automatic int limit_range(input int v, input int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Random report: mostly near the rest values so snapping and small moves occur
    function automatic report_t random_report();
        report_t r;
        int      pick;
        int      ax;
        int      spread;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            spread = 3;
        else if (pick < 85)
            spread = 40;
        else
            spread = 0;
        if (spread == 0)
        begin
            r.joy_x = 8'($urandom);
            r.joy_y = 8'($urandom);
            ax = $urandom_range(0, 1023);
        end
        else
        begin
            r.joy_x = 8'(limit_range(jx_center + $urandom_range(0, 2 * spread) - spread, 255));
            r.joy_y = 8'(limit_range(jy_center + $urandom_range(0, 2 * spread) - spread, 255));
            ax = limit_range(ax_center + $urandom_range(0, 30) - 15, 1023);
        end
        if ($urandom_range(0, 4) == 0)
            btn_bits = 2'($urandom);
        r.accel_high = 8'(ax >> 2);
        r.flags = {4'($urandom), 2'(ax), btn_bits};
        r.quiet = ($urandom_range(0, 4) == 0);
        return r;
    endfunction

    // Directed rows: quiet, flags, accel_high, joy_y, joy_x | typed, has_event | event
    stim_row_t dir_rows [DIR_ROWS] = '{
        // after reset: nothing moves, buttons released
        '{'{1'b0, 8'h03, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, NO_EV},
        // Z pressed, then C pressed
        '{'{1'b0, 8'h02, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b1, Z_DOWN},
        '{'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b1, C_DOWN},
        // release both while quiet: no events
        '{'{1'b1, 8'h03, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, NO_EV},
        // extremes
        '{'{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_EV},
        '{'{1'b1, 8'hFC, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 1'b0, NO_EV},
        // fill the window at the rest value so the joystick means snap to center
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h80, 8'h80, 8'h80}, 1'b0, 1'b0, NO_EV},
        // just off center, then opposite corners
        '{'{1'b0, 8'h07, 8'h80, 8'h7F, 8'h81}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h0C, 8'hFF, 8'hFF, 8'h00}, 1'b0, 1'b0, NO_EV},
        '{'{1'b1, 8'hF1, 8'h00, 8'h00, 8'hFF}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, 1'b0, NO_EV},
        '{'{1'b0, 8'h03, 8'h00, 8'h00, 8'h00}, 1'b0, 1'b0, NO_EV}
    };

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        int mode = 0;
        int phase_cnt = 0;
        int hold_left = 0;
        int holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (phase_cnt == 0)
            begin
                mode = $urandom_range(0, 3);
                phase_cnt = $urandom_range(16, 96);
            end
            phase_cnt--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom);
                    2: m_axis_tready <= (phase_cnt % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each event transfer with the oldest expectation
    always @(posedge clk)
    begin
        filter_event_t exp_ev;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event kind %0d channel %0d offset %0d", $time,
                         m_axis_tuser[KIND_LSB+1:KIND_LSB],
                         m_axis_tuser[CHAN_BIT], $signed(m_axis_tdata[OFF_W-1:0]));
                errors++;
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (m_axis_tuser[KIND_LSB+1:KIND_LSB] != exp_ev.ev.kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time, exp_ev.ev.kind,
                             m_axis_tuser[KIND_LSB+1:KIND_LSB]);
                    errors++;
                end
                if (m_axis_tuser[CHAN_BIT] != exp_ev.ev.chan)
                begin
                    $display("%0t: channel expected %0d actual %0d", $time, exp_ev.ev.chan,
                             m_axis_tuser[CHAN_BIT]);
                    errors++;
                end
                if (m_axis_tdata[OFF_W-1:0] != exp_ev.ev.offset)
                begin
                    $display("%0t: offset expected %0d actual %0d", $time,
                             $signed(exp_ev.ev.offset), $signed(m_axis_tdata[OFF_W-1:0]));
                    errors++;
                end
                if (m_axis_tlast != exp_ev.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time, exp_ev.last,
                             m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int wait_cycles;
        int jxc;
        int jyc;
        int axc;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows with reset centers
        for (int i = 0; i < DIR_ROWS; i++)
            send_report(dir_rows[i].rpt, dir_rows[i].typed, dir_rows[i].has_event,
                        dir_rows[i].ev);
        settle_block();

        // Random phases, each with its own centers
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin jxc = 128; jyc = 128; axc = 0;    end
                1: begin jxc = 0;   jyc = 0;   axc = 0;    end
                2: begin jxc = 255; jyc = 255; axc = 1023; end
                3: begin jxc = 100; jyc = 200; axc = 512;  end
                default:
                begin
                    jxc = $urandom_range(0, 255);
                    jyc = $urandom_range(0, 255);
                    axc = $urandom_range(0, 1023);
                end
            endcase
            write_center(jaef_pkg::CFG_JOY_X_CENTER, jxc);
            write_center(jaef_pkg::CFG_JOY_Y_CENTER, jyc);
            write_center(jaef_pkg::CFG_ACCEL_X_CENTER, axc);

            no_gaps = (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_report(random_report(), 1'b0, 1'b0, NO_EV);

            // Hold off the receiver and keep offering reports back to back
            if (phase == 3)
            begin
                hold_requests++;
                no_gaps = 1'b1;
                for (int n = 0; n < FILL_ITEMS; n++)
                    send_report(random_report(), 1'b0, 1'b0, NO_EV);
                no_gaps = 1'b0;
            end
            settle_block();
        end

        // Drain with a bound, then let the pipeline go quiet
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_events.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (BLOCK_LATENCY) @(posedge clk);

        if (pending_events.size() != 0)
            $display("%0t: %0d expected events never arrived", $time, pending_events.size());
        if (errors == 0 && pending_events.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
